### sv/gsa_pkg.sv
// Shared constants for the generational slot allocator.
// Pool size, derived widths, command and status codes. No dependencies.
package gsa_pkg;

	localparam int unsigned Slots = 4096;
	localparam int unsigned AW    = $clog2(Slots);
	localparam int unsigned CW    = $clog2(Slots + 1);
	localparam int unsigned GW    = 32;

	localparam logic [1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_CHECK   = 2'd2;
	localparam logic [1:0] CMD_RESET   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_STALE = 2'd2;
	localparam logic [1:0] ST_RESET = 2'd3;

endpackage

### sv/gsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the slot table and the free stack. No dependencies.
module gsa_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/generational_slot_allocator_top.sv
// Generational slot allocator: slot table {recycled, generation} and free stack in RAM.
// Acquire on an empty or unset pool, and null or out-of-range handles, are answered straight from idle;
// release and check pass through S_EVAL, acquire through S_POP and S_GRANT, reset pool walks all slots in S_WALK.
// One item at a time: busy stays high until the result strobe, set by the RAM read-modify-write.
// The receiver cannot stall. Reset clears the pool to not set up; the RAMs need no clearing.
// Depends on gsa_pkg and gsa_ram.
module generational_slot_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic        handle_present,
	input  logic [11:0] slot_index,
	input  logic [31:0] handle_generation,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] granted_slot,
	output logic [31:0] granted_generation,
	output logic        is_current
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_POP   = 3'd1;
	localparam logic [2:0] S_GRANT = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;

	localparam int unsigned AW = gsa_pkg::AW;
	localparam int unsigned CW = gsa_pkg::CW;
	localparam int unsigned GW = gsa_pkg::GW;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic          ready_q;
	logic [CW-1:0] walk_q;
	logic [1:0]    cmd_q;
	logic [AW-1:0] slot_q;
	logic [GW-1:0] hgen_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [11:0]   gslot_q;
	logic [GW-1:0] ggen_q;
	logic          cur_q;

	logic          sm_we;
	logic [AW-1:0] sm_waddr;
	logic [GW:0]   sm_wdata;
	logic [AW-1:0] sm_raddr;
	logic [GW:0]   sm_rdata;
	logic          fs_we;
	logic [AW-1:0] fs_waddr;
	logic [AW-1:0] fs_wdata;
	logic [AW-1:0] fs_raddr;
	logic [AW-1:0] fs_rdata;

	logic          accept;
	logic          in_range;
	logic          hdl_ok;
	logic [AW-1:0] in_slot;
	logic          live;
	logic [GW-1:0] old_gen;
	logic [AW-1:0] walk_prev;

	assign accept    = start && (state_q == S_IDLE);
	assign in_range  = 32'(slot_index) < 32'(gsa_pkg::Slots);
	assign in_slot   = AW'(slot_index);
	assign hdl_ok    = handle_present && in_range && ready_q;
	assign live      = (sm_rdata[GW-1:0] == hgen_q) && !sm_rdata[GW];
	assign old_gen   = ready_q ? sm_rdata[GW-1:0] : '0;
	assign walk_prev = AW'(walk_q - CW'(1));

	always_comb begin
		sm_we    = 1'b0;
		sm_waddr = slot_q;
		sm_wdata = '0;
		sm_raddr = in_slot;
		fs_we    = 1'b0;
		fs_waddr = AW'(count_q);
		fs_wdata = slot_q;
		fs_raddr = AW'(count_q - CW'(1));
		case (state_q)
			S_IDLE: begin
				if (command == gsa_pkg::CMD_RESET) begin
					sm_raddr = '0;
				end
			end
			S_POP: begin
				sm_raddr = fs_rdata;
			end
			S_GRANT: begin
				sm_we    = 1'b1;
				sm_wdata = {1'b0, sm_rdata[GW-1:0] + GW'(1)};
			end
			S_EVAL: begin
				if (cmd_q == gsa_pkg::CMD_RELEASE && live) begin
					sm_we    = 1'b1;
					sm_wdata = {1'b1, sm_rdata[GW-1:0]};
					fs_we    = count_q < CW'(gsa_pkg::Slots);
				end
			end
			S_WALK: begin
				sm_we    = 1'b1;
				sm_waddr = walk_prev;
				sm_wdata = {1'b1, old_gen + GW'(1)};
				sm_raddr = AW'(walk_q);
				fs_we    = 1'b1;
				fs_waddr = walk_prev;
				fs_wdata = walk_prev;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ready_q  <= 1'b0;
			walk_q   <= '0;
			cmd_q    <= gsa_pkg::CMD_ACQUIRE;
			slot_q   <= '0;
			hgen_q   <= '0;
			done_q   <= 1'b0;
			status_q <= gsa_pkg::ST_OK;
			gslot_q  <= '0;
			ggen_q   <= '0;
			cur_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= command;
						slot_q   <= in_slot;
						hgen_q   <= handle_generation;
						status_q <= gsa_pkg::ST_OK;
						gslot_q  <= '0;
						ggen_q   <= '0;
						cur_q    <= 1'b0;
						case (command)
							gsa_pkg::CMD_ACQUIRE: begin
								if (!ready_q || count_q == '0) begin
									status_q <= gsa_pkg::ST_EMPTY;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_POP;
								end
							end
							gsa_pkg::CMD_RELEASE: begin
								if (hdl_ok) begin
									state_q <= S_EVAL;
								end else begin
									status_q <= gsa_pkg::ST_STALE;
									done_q   <= 1'b1;
								end
							end
							gsa_pkg::CMD_CHECK: begin
								if (hdl_ok) begin
									state_q <= S_EVAL;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								walk_q  <= CW'(1);
								state_q <= S_WALK;
							end
						endcase
					end
				end
				S_POP: begin
					count_q <= count_q - CW'(1);
					slot_q  <= fs_rdata;
					state_q <= S_GRANT;
				end
				S_GRANT: begin
					gslot_q <= 12'(slot_q);
					ggen_q  <= sm_rdata[GW-1:0] + GW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_EVAL: begin
					if (cmd_q == gsa_pkg::CMD_CHECK) begin
						cur_q <= live;
					end else if (!live) begin
						status_q <= gsa_pkg::ST_STALE;
					end else if (count_q < CW'(gsa_pkg::Slots)) begin
						count_q <= count_q + CW'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_WALK: begin
					if (walk_q == CW'(gsa_pkg::Slots)) begin
						count_q  <= CW'(gsa_pkg::Slots);
						ready_q  <= 1'b1;
						status_q <= gsa_pkg::ST_RESET;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						walk_q <= walk_q + CW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	gsa_ram #(
		.Width(GW + 1),
		.Depth(gsa_pkg::Slots)
	) u_slot_ram (
		.clk  (clk),
		.we   (sm_we),
		.waddr(sm_waddr),
		.wdata(sm_wdata),
		.raddr(sm_raddr),
		.rdata(sm_rdata)
	);

	gsa_ram #(
		.Width(AW),
		.Depth(gsa_pkg::Slots)
	) u_stack_ram (
		.clk  (clk),
		.we   (fs_we),
		.waddr(fs_waddr),
		.wdata(fs_wdata),
		.raddr(fs_raddr),
		.rdata(fs_rdata)
	);

	assign busy               = (state_q != S_IDLE);
	assign done               = done_q;
	assign status             = status_q;
	assign granted_slot       = gslot_q;
	assign granted_generation = ggen_q;
	assign is_current         = cur_q;

endmodule
